### design/gfill_pkg.sv
// ----------------------------------------------------------------------------
// gfill_pkg
// Shared types and constants of the RGB565 horizontal gradient fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package gfill_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int COLOR_W = 16;
  localparam int DIM_W   = 9;
  localparam int DIV_W   = DIM_W;

  localparam int RED_W   = 5;
  localparam int GREEN_W = 6;
  localparam int BLUE_W  = 5;
  localparam int RED_LSB   = 11;
  localparam int GREEN_LSB = 5;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_START_COLOR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_COLOR   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT = 2'd3;

  typedef struct packed {
    logic start;
    logic div_step;
    logic latch_steps;
    logic emit;
  } gfill_cmd_t;

  typedef struct packed {
    logic in_progress;
    logic out_free;
  } gfill_status_t;

endpackage

`default_nettype wire

### design/gfill_if.sv
// ----------------------------------------------------------------------------
// gfill_if
// Handshake channels of the gradient fill block: request, pixel, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfill_item_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface gfill_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [gfill_pkg::COLOR_W-1:0] pixel_color;
  logic                         row_end;
  logic                         rect_end;

  modport source (output valid, output pixel_color, output row_end, output rect_end,
                  input ready);
  modport sink   (input valid, input pixel_color, input row_end, input rect_end,
                  output ready);
endinterface

interface gfill_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gfill_pkg::CFG_INDEX_W-1:0] index;
  logic [gfill_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/gfill_div.sv
// ----------------------------------------------------------------------------
// gfill_div
// Restoring divider, one quotient bit per step, for one color channel step.
// ----------------------------------------------------------------------------
`default_nettype none

module gfill_div #(
  parameter int QW = gfill_pkg::FRAC_BITS_DEFAULT + gfill_pkg::GREEN_W
) (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic                         step,
  input  wire logic [QW-1:0]                dividend,
  input  wire logic [gfill_pkg::DIV_W-1:0]  divisor,
  output logic      [QW-1:0]                quotient
);

  localparam int DW = gfill_pkg::DIV_W;

  logic [QW-1:0] work;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem, work[QW-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= dividend;
      rem  <= '0;
    end else if (step) begin
      work <= {work[QW-2:0], ge};
      rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quotient = work;

endmodule

`default_nettype wire

### design/gfill_datapath.sv
// ----------------------------------------------------------------------------
// gfill_datapath
// Config registers, step dividers, channel accumulators, counters, output.
// ----------------------------------------------------------------------------
`default_nettype none

module gfill_datapath #(
  parameter int FRAC_BITS = gfill_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  gfill_cfg_if.sink                  cfg,
  gfill_pixel_if.source              pixel,
  input  wire gfill_pkg::gfill_cmd_t cmd,
  output gfill_pkg::gfill_status_t   status
);

  localparam int RW = gfill_pkg::RED_W + FRAC_BITS;
  localparam int GW = gfill_pkg::GREEN_W + FRAC_BITS;
  localparam int BW = gfill_pkg::BLUE_W + FRAC_BITS;
  localparam int QW = GW;
  localparam int DM = gfill_pkg::DIM_W;

  logic [gfill_pkg::COLOR_W-1:0] start_color;
  logic [gfill_pkg::COLOR_W-1:0] end_color;
  logic [DM-1:0] rect_width;
  logic [DM-1:0] rect_height;

  logic [RW-1:0] red_accum;
  logic [GW-1:0] green_accum;
  logic [BW-1:0] blue_accum;
  logic [RW-1:0] red_step;
  logic [GW-1:0] green_step;
  logic [BW-1:0] blue_step;
  logic [DM-1:0] column_count;
  logic [DM-1:0] row_count;
  logic          in_progress;
  logic          red_neg;
  logic          green_neg;
  logic          blue_neg;
  logic          out_valid;

  logic [DM-1:0] w;
  logic [DM-1:0] h;
  logic          row_last;
  logic          rect_last;

  logic [gfill_pkg::RED_W-1:0]   red_s, red_e, red_d;
  logic [gfill_pkg::GREEN_W-1:0] green_s, green_e, green_d;
  logic [gfill_pkg::BLUE_W-1:0]  blue_s, blue_e, blue_d;
  logic [QW-1:0] red_q, green_q, blue_q;

  always_comb begin
    red_s   = start_color[gfill_pkg::RED_LSB +: gfill_pkg::RED_W];
    red_e   = end_color[gfill_pkg::RED_LSB +: gfill_pkg::RED_W];
    green_s = start_color[gfill_pkg::GREEN_LSB +: gfill_pkg::GREEN_W];
    green_e = end_color[gfill_pkg::GREEN_LSB +: gfill_pkg::GREEN_W];
    blue_s  = start_color[gfill_pkg::BLUE_W-1:0];
    blue_e  = end_color[gfill_pkg::BLUE_W-1:0];
    red_d   = (red_e >= red_s) ? red_e - red_s : red_s - red_e;
    green_d = (green_e >= green_s) ? green_e - green_s : green_s - green_e;
    blue_d  = (blue_e >= blue_s) ? blue_e - blue_s : blue_s - blue_e;
    w = (rect_width == '0) ? DM'(1) : rect_width;
    h = (rect_height == '0) ? DM'(1) : rect_height;
    row_last  = ({1'b0, column_count} + (DM+1)'(1)) >= {1'b0, w};
    rect_last = row_last && (({1'b0, row_count} + (DM+1)'(1)) >= {1'b0, h});
  end

  gfill_div #(.QW(QW)) u_red_div (
    .clk(clk), .load(cmd.start), .step(cmd.div_step),
    .dividend(QW'(red_d) << FRAC_BITS), .divisor(w), .quotient(red_q)
  );

  gfill_div #(.QW(QW)) u_green_div (
    .clk(clk), .load(cmd.start), .step(cmd.div_step),
    .dividend(QW'(green_d) << FRAC_BITS), .divisor(w), .quotient(green_q)
  );

  gfill_div #(.QW(QW)) u_blue_div (
    .clk(clk), .load(cmd.start), .step(cmd.div_step),
    .dividend(QW'(blue_d) << FRAC_BITS), .divisor(w), .quotient(blue_q)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_color <= '0;
      end_color   <= '0;
      rect_width  <= DM'(1);
      rect_height <= DM'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        gfill_pkg::REG_START_COLOR: start_color <= cfg.data;
        gfill_pkg::REG_END_COLOR:   end_color   <= cfg.data;
        gfill_pkg::REG_RECT_WIDTH:  rect_width  <= cfg.data[DM-1:0];
        gfill_pkg::REG_RECT_HEIGHT: rect_height <= cfg.data[DM-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      in_progress  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.start) begin
        column_count <= '0;
        row_count    <= '0;
        in_progress  <= 1'b1;
      end else if (cmd.emit) begin
        if (row_last) begin
          column_count <= '0;
          if (rect_last) begin
            row_count   <= '0;
            in_progress <= 1'b0;
          end else begin
            row_count <= row_count + DM'(1);
          end
        end else begin
          column_count <= column_count + DM'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (pixel.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || (cmd.emit && row_last)) begin
      red_accum   <= {red_s, {FRAC_BITS{1'b0}}};
      green_accum <= {green_s, {FRAC_BITS{1'b0}}};
      blue_accum  <= {blue_s, {FRAC_BITS{1'b0}}};
    end else if (cmd.emit) begin
      red_accum   <= red_accum + red_step;
      green_accum <= green_accum + green_step;
      blue_accum  <= blue_accum + blue_step;
    end
    if (cmd.start) begin
      red_neg   <= red_e < red_s;
      green_neg <= green_e < green_s;
      blue_neg  <= blue_e < blue_s;
    end
    if (cmd.latch_steps) begin
      red_step   <= red_neg ? RW'(QW'(0) - red_q) : RW'(red_q);
      green_step <= green_neg ? GW'(QW'(0) - green_q) : GW'(green_q);
      blue_step  <= blue_neg ? BW'(QW'(0) - blue_q) : BW'(blue_q);
    end
    if (cmd.emit) begin
      pixel.pixel_color <= {red_accum[RW-1:FRAC_BITS], green_accum[GW-1:FRAC_BITS],
                            blue_accum[BW-1:FRAC_BITS]};
      pixel.row_end     <= row_last;
      pixel.rect_end    <= rect_last;
    end
  end

  assign pixel.valid        = out_valid;
  assign status.in_progress = in_progress;
  assign status.out_free    = !out_valid || pixel.ready;

endmodule

`default_nettype wire

### design/gfill_ctrl.sv
// ----------------------------------------------------------------------------
// gfill_ctrl
// Sequencer: accepts requests, runs the step division, issues pixel emits.
// ----------------------------------------------------------------------------
`default_nettype none

module gfill_ctrl #(
  parameter int FRAC_BITS = gfill_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  gfill_item_if.sink                   item,
  output gfill_pkg::gfill_cmd_t        cmd,
  input  wire gfill_pkg::gfill_status_t status
);

  localparam int QW = gfill_pkg::GREEN_W + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_LATCH = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] count;
  logic          accept;

  always_comb begin
    item.ready = (state == S_RUN) && status.out_free;
    accept     = item.valid && item.ready;
    cmd        = '0;
    state_next = state;
    case (state)
      S_RUN: begin
        if (accept) begin
          if (item.restart || !status.in_progress) begin
            cmd.start  = 1'b1;
            state_next = S_DIV;
          end else begin
            cmd.emit = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (count == CW'(QW - 1)) begin
          state_next = S_LATCH;
        end
      end
      S_LATCH: begin
        cmd.latch_steps = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        count <= '0;
      end else if (cmd.div_step) begin
        count <= count + CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emit issued while output register is occupied");

  a_start_div: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_DIV) && (count == '0))
    else $error("division did not begin after a new rectangle");

  a_accept_acted: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |-> (cmd.start || cmd.emit))
    else $error("accepted request neither started a rectangle nor emitted");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_LATCH) |-> $past(cmd.div_step) && ($past(count) == CW'(QW - 1)))
    else $error("step latch reached before division finished");
`endif

endmodule

`default_nettype wire

### design/rgb565_horizontal_gradient_fill.sv
// ----------------------------------------------------------------------------
// rgb565_horizontal_gradient_fill
// Streams an RGB565 rectangle, row by row, with a horizontal linear gradient.
// ----------------------------------------------------------------------------
// Channels: item carries one request per pixel (restart begins a new
// rectangle); pixel returns one result per request with pixel_color,
// row_end and rect_end; cfg writes start_color, end_color, rect_width and
// rect_height by index 0..3 and is always ready.
// A request that begins a rectangle (restart, or none in progress) runs the
// per-channel step division, one quotient bit per cycle, then latches the
// steps and emits its pixel once the output register is free. Every other
// request is accepted and emitted in the same cycle, its pixel valid on the
// next cycle, one pixel per cycle sustained while the pixel receiver keeps
// ready high.
// Reset restores the register defaults (width and height 1) and leaves no
// rectangle in progress. When the pixel receiver stalls, the output register
// holds its pixel and item ready drops until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_horizontal_gradient_fill #(
  parameter int FRAC_BITS = gfill_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  gfill_item_if.sink    item,
  gfill_pixel_if.source pixel,
  gfill_cfg_if.sink     cfg
);

  gfill_pkg::gfill_cmd_t    cmd;
  gfill_pkg::gfill_status_t status;

  gfill_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status)
  );

  gfill_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixel  (pixel),
    .cmd    (cmd),
    .status (status)
  );

endmodule

`default_nettype wire
